[rtl/point_update_range_sum_tree_macros.svh]
// Assertion macros for the checker file of the range-sum tree.
// Depends on nothing; users provide clk_i and rst_ni in scope.
`ifndef POINT_UPDATE_RANGE_SUM_TREE_MACROS_SVH
`define POINT_UPDATE_RANGE_SUM_TREE_MACROS_SVH

// same-cycle implication
`define PURST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PURST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/purst_pkg.sv]
// Package for the range-sum tree: field widths, word types, control structs.
// No dependencies.
package purst_pkg;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned CNT_W = 11;
  localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

  localparam logic FUNC_SET   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                    func;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        last_index;
    logic signed [VAL_W-1:0] new_value;
  } in_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] range_sum;
    logic                    range_error;
  } out_word_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic set_leaf;
    logic set_up;
    logic qry_step;
    logic result;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_set;
    logic set_ok;
    logic qry_ok;
    logic more;
    logic p_last;
  } sts_t;

endpackage

[rtl/point_update_range_sum_tree.sv]
// Top level of the point-update range-sum tree.
// Depends on purst_pkg, purst_ctrl and purst_datapath.
//
// Segment tree of 48-bit partial sums over ELEMENTS signed 32-bit values,
// one node store of 2*ELEMENTS words. After reset the block clears the store,
// one word a cycle, with busy held high throughout. A word is taken when start
// is high and busy low; one item is in work at a time. A set walks from leaf
// to root, one tree level a cycle through the single store write port; a set
// outside the element count is dropped without a write. A query walks both
// range ends upward together, one level a cycle on the two store read ports,
// and strobes res_valid_o for one cycle; a flagged query skips the walk.
// Results cannot be held off.
// element_count may be written only while busy is low.
module point_update_range_sum_tree import purst_pkg::*; #(
  parameter int unsigned ELEMENTS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  in_word_t         in_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  output logic             res_valid_o,
  output out_word_t        res_o
);

  cmd_t cmd;
  sts_t sts;

  purst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  purst_datapath #(
    .ELEMENTS (ELEMENTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

[rtl/purst_ctrl.sv]
// Sequencer for the range-sum tree: clearing pass, set walk, query walk.
// Depends on purst_pkg.
module purst_ctrl import purst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_CLEAR    = 7'b0000001,
    ST_IDLE     = 7'b0000010,
    ST_DECODE   = 7'b0000100,
    ST_SET_LEAF = 7'b0001000,
    ST_SET_UP   = 7'b0010000,
    ST_QRY_WALK = 7'b0100000,
    ST_RESULT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.is_set) begin
          state_d = sts_i.set_ok ? ST_SET_LEAF : ST_IDLE;
        end else begin
          state_d = sts_i.qry_ok ? ST_QRY_WALK : ST_RESULT;
        end
      end
      ST_SET_LEAF: begin
        cmd_o.set_leaf = 1'b1;
        state_d        = ST_SET_UP;
      end
      ST_SET_UP: begin
        cmd_o.set_up = 1'b1;
        if (sts_i.p_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_QRY_WALK: begin
        if (sts_i.more) begin
          cmd_o.qry_step = 1'b1;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        cmd_o.result = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

[rtl/purst_datapath.sv]
// Datapath of the range-sum tree: node store, path pointers, accumulators.
// Depends on purst_pkg; sequenced by purst_ctrl.
module purst_datapath import purst_pkg::*; #(
  parameter int unsigned ELEMENTS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  in_word_t         in_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  output logic             res_valid_o,
  output out_word_t        res_o
);

  localparam int unsigned DEPTH = 2 * ELEMENTS;
  localparam int unsigned NW    = $clog2(DEPTH);
  localparam int unsigned PW    = NW + 1;
  localparam int unsigned CW    = (PW > CNT_W) ? PW + 1 : CNT_W + 1;

  logic signed [SUM_W-1:0] mem_q [DEPTH];
  logic signed [SUM_W-1:0] rd0_q, rd1_q;

  logic [CNT_W-1:0]        count_q;
  in_word_t                item_q;
  logic                    set_ok_q, qry_ok_q;
  logic [NW-1:0]           p_q, p_d;
  logic [PW-1:0]           l_q, l_d, r_q, r_d, r_m1, l_p1;
  logic signed [SUM_W-1:0] diff_q;
  logic signed [SUM_W-1:0] acc_l_q, acc_r_q;
  logic                    take_l_q, take_r_q;
  logic [NW-1:0]           clr_q;
  logic                    res_valid_q;
  out_word_t               res_q;

  logic [CW-1:0]           first_w, last_w, lim_w, leaf_w, rend_w;
  logic [NW-1:0]           addr0, addr1, waddr;
  logic                    we;
  logic signed [SUM_W-1:0] wdata, new_ext;

  assign first_w = CW'(in_i.first_index);
  assign last_w  = CW'(in_i.last_index);
  assign lim_w   = (CW'(count_q) > CW'(ELEMENTS)) ? CW'(ELEMENTS) : CW'(count_q);
  assign leaf_w  = CW'(ELEMENTS) + first_w;
  assign rend_w  = CW'(ELEMENTS) + last_w + CW'(1);

  assign new_ext = {{(SUM_W-VAL_W){item_q.new_value[VAL_W-1]}}, item_q.new_value};

  always_comb begin
    p_d = p_q;
    if (cmd_i.load) begin
      p_d = leaf_w[NW-1:0];
    end else if (cmd_i.set_leaf || cmd_i.set_up) begin
      p_d = p_q >> 1;
    end
  end

  assign l_p1  = l_q + PW'(1);
  assign l_d   = l_p1 >> 1;
  assign r_d   = r_q >> 1;
  assign r_m1  = r_q - PW'(1);

  assign addr0 = (item_q.func == FUNC_SET) ? p_d : l_q[NW-1:0];
  assign addr1 = r_m1[NW-1:0];

  assign we    = cmd_i.clr || cmd_i.set_leaf || cmd_i.set_up;
  assign waddr = cmd_i.clr ? clr_q : p_q;

  always_comb begin
    if (cmd_i.clr) begin
      wdata = '0;
    end else if (cmd_i.set_leaf) begin
      wdata = new_ext;
    end else begin
      wdata = rd0_q + diff_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd0_q <= mem_q[addr0];
    rd1_q <= mem_q[addr1];
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CNT_RESET;
      clr_q       <= '0;
      take_l_q    <= 1'b0;
      take_r_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + NW'(1);
      end
      take_l_q    <= cmd_i.qry_step && l_q[0];
      take_r_q    <= cmd_i.qry_step && r_q[0];
      res_valid_q <= cmd_i.result;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (cmd_i.load) begin
      item_q   <= in_i;
      set_ok_q <= (first_w < lim_w);
      qry_ok_q <= (first_w <= last_w) && (last_w < lim_w);
      l_q      <= leaf_w[PW-1:0];
      r_q      <= rend_w[PW-1:0];
      acc_l_q  <= '0;
      acc_r_q  <= '0;
    end else begin
      if (cmd_i.qry_step) begin
        l_q <= l_d;
        r_q <= r_d;
      end
      if (take_l_q) begin
        acc_l_q <= acc_l_q + rd0_q;
      end
      if (take_r_q) begin
        acc_r_q <= acc_r_q + rd1_q;
      end
    end
    if (cmd_i.set_leaf) begin
      diff_q <= new_ext - rd0_q;
    end
    if (cmd_i.result) begin
      res_q.range_error <= !qry_ok_q;
      res_q.range_sum   <= qry_ok_q ? (acc_l_q + acc_r_q) : '0;
    end
  end

  assign sts_o.clr_last = (clr_q == NW'(DEPTH - 1));
  assign sts_o.is_set   = (item_q.func == FUNC_SET);
  assign sts_o.set_ok   = set_ok_q;
  assign sts_o.qry_ok   = qry_ok_q;
  assign sts_o.more     = (l_q < r_q);
  assign sts_o.p_last   = (p_q == NW'(1));

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[rtl/purst_checker.sv]
// Port-level checks for the range-sum tree, bound to the top level.
// Depends on purst_pkg and point_update_range_sum_tree_macros.svh.
`include "point_update_range_sum_tree_macros.svh"

module purst_checker import purst_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input logic      busy_i,
  input logic      res_valid_i,
  input out_word_t res_i
);

  `PURST_ASSERT_NEXT(a_accept_busy, start_i && !busy_i, busy_i, "accepted word did not raise busy")
  `PURST_ASSERT_NOW(a_res_after_busy, res_valid_i, $past(busy_i), "result without work")
  `PURST_ASSERT_NEXT(a_res_strobe, res_valid_i, !res_valid_i, "result strobe longer than a cycle")
  `PURST_ASSERT_NOW(a_err_zero, res_valid_i && res_i.range_error, res_i.range_sum == '0, "flagged result carries a sum")

endmodule

bind point_update_range_sum_tree purst_checker u_purst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start),
  .busy_i      (busy),
  .res_valid_i (res_valid_o),
  .res_i       (res_o)
);
